/* design/e2q_pkg.sv */
// ----------------------------------------------------------------------------
// e2q_pkg
// shared types, constants and tables for the euler to quaternion core
// ----------------------------------------------------------------------------
`default_nettype none
package e2q_pkg;
	localparam int WFRAC = 30;
	localparam int ATAN_ENTRIES = 24;
	// working width for cordic x, y, z (30 fraction bits plus sign and headroom)
	localparam int CW = 33;
	localparam logic signed [15:0] QUARTER_TURN_RAW = 16'sd11520;
	localparam logic signed [16:0] HALF_TURN_RAW = 17'sd23040;
	localparam logic signed [28:0] RAD_SCALE = 29'sd149922641;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

	typedef logic signed [CW-1:0] cw_t;

	// one lane result: half-angle sine and cosine
	typedef struct packed {
		cw_t s;
		cw_t c;
	} sincos_t;

	function automatic cw_t atan_val(input int i);
		cw_t r;
		unique case (i)
			0: r = 33'sh3243F6A8;
			1: r = 33'sh1DAC6705;
			2: r = 33'sh0FADBAFC;
			3: r = 33'sh07F56EA6;
			4: r = 33'sh03FEAB76;
			5: r = 33'sh01FFD55B;
			6: r = 33'sh00FFFAAA;
			7: r = 33'sh007FFF55;
			8: r = 33'sh003FFFEA;
			9: r = 33'sh001FFFFD;
			10: r = 33'sh000FFFFF;
			11: r = 33'sh0007FFFF;
			12: r = 33'sh0003FFFF;
			13: r = 33'sh0001FFFF;
			14: r = 33'sh0000FFFF;
			15: r = 33'sh00007FFF;
			16: r = 33'sh00003FFF;
			17: r = 33'sh00001FFF;
			18: r = 33'sh00000FFF;
			19: r = 33'sh000007FF;
			20: r = 33'sh000003FF;
			21: r = 33'sh000001FF;
			22: r = 33'sh000000FF;
			23: r = 33'sh0000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

	// round-half-up product of two 30-fraction values
	function automatic cw_t mul30(input cw_t a, input cw_t b);
		logic signed [2*CW-1:0] p;
		p = (2*CW)'(a) * (2*CW)'(b) + (2*CW)'(64'sd1 <<< (WFRAC - 1));
		return CW'(p >>> WFRAC);
	endfunction
endpackage
`default_nettype wire

/* design/e2q_lane.sv */
// ----------------------------------------------------------------------------
// e2q_lane
// pipelined half-angle sine/cosine: range reduce, scale, cordic stages
// ----------------------------------------------------------------------------
`default_nettype none
module e2q_lane #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire                           clk,
	input  wire                           en,
	input  wire logic signed [15:0]       ang,
	output e2q_pkg::sincos_t              sc
);
	localparam int N = (CORDIC_STAGES < e2q_pkg::ATAN_ENTRIES) ?
		CORDIC_STAGES : e2q_pkg::ATAN_ENTRIES;

	logic signed [16:0] red;
	logic               neg_c;
	logic signed [16:0] red_s1;
	logic               neg_s1;
	e2q_pkg::cw_t       x_q [0:N];
	e2q_pkg::cw_t       y_q [0:N];
	e2q_pkg::cw_t       z_q [0:N];
	logic               neg_q [0:N];
	logic signed [46:0] zprod;

	always_comb begin
		red = 17'(ang);
		neg_c = 1'b0;
		if (ang > e2q_pkg::QUARTER_TURN_RAW) begin
			red = 17'(ang) - e2q_pkg::HALF_TURN_RAW;
			neg_c = 1'b1;
		end else if (ang < -e2q_pkg::QUARTER_TURN_RAW) begin
			red = 17'(ang) + e2q_pkg::HALF_TURN_RAW;
			neg_c = 1'b1;
		end
		zprod = 47'(red_s1) * 47'(e2q_pkg::RAD_SCALE) + 47'sd512;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1 <= red;
			neg_s1 <= neg_c;
			x_q[0] <= e2q_pkg::CORDIC_GAIN;
			y_q[0] <= '0;
			z_q[0] <= e2q_pkg::CW'(zprod >>> 10);
			neg_q[0] <= neg_s1;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				neg_q[i+1] <= neg_q[i];
				if (!z_q[i][e2q_pkg::CW-1]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - e2q_pkg::atan_val(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + e2q_pkg::atan_val(i);
				end
			end
		end
	end

	assign sc.c = neg_q[N] ? -x_q[N] : x_q[N];
	assign sc.s = neg_q[N] ? -y_q[N] : y_q[N];
endmodule
`default_nettype wire

/* design/e2q_merge.sv */
// ----------------------------------------------------------------------------
// e2q_merge
// combines three lanes' sine/cosine into w,x,y,z with rounding and clamp
// ----------------------------------------------------------------------------
`default_nettype none
module e2q_merge #(
	parameter int OUT_FRAC_BITS = 14
) (
	input  wire                     clk,
	input  wire                     en,
	input  e2q_pkg::sincos_t        r,
	input  e2q_pkg::sincos_t        p,
	input  e2q_pkg::sincos_t        y,
	output logic signed [15:0]      qw,
	output logic signed [15:0]      qx,
	output logic signed [15:0]      qy,
	output logic signed [15:0]      qz
);
	localparam int SH = e2q_pkg::WFRAC - OUT_FRAC_BITS;
	e2q_pkg::cw_t cc_s1, ss_s1, sc_s1, cs_s1, cy_s1, sy_s1;
	e2q_pkg::cw_t ccc_s2, sss_s2, scc_s2, css_s2, csc_s2, scs_s2, ccs_s2, ssc_s2;
	e2q_pkg::cw_t w_s3, x_s3, y_s3, z_s3;

	function automatic logic signed [15:0] finish(input e2q_pkg::cw_t v);
		logic signed [e2q_pkg::CW:0] t;
		t = (e2q_pkg::CW+1)'(v);
		if (SH > 0) t = (t + ((e2q_pkg::CW+1)'(1) <<< (SH - 1))) >>> SH;
		if (t > 32767) return 16'sh7fff;
		if (t < -32768) return 16'sh8000;
		return 16'(t);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s1 <= e2q_pkg::mul30(r.c, p.c);
			ss_s1 <= e2q_pkg::mul30(r.s, p.s);
			sc_s1 <= e2q_pkg::mul30(r.s, p.c);
			cs_s1 <= e2q_pkg::mul30(r.c, p.s);
			cy_s1 <= y.c;
			sy_s1 <= y.s;
			ccc_s2 <= e2q_pkg::mul30(cc_s1, cy_s1);
			sss_s2 <= e2q_pkg::mul30(ss_s1, sy_s1);
			scc_s2 <= e2q_pkg::mul30(sc_s1, cy_s1);
			css_s2 <= e2q_pkg::mul30(cs_s1, sy_s1);
			csc_s2 <= e2q_pkg::mul30(cs_s1, cy_s1);
			scs_s2 <= e2q_pkg::mul30(sc_s1, sy_s1);
			ccs_s2 <= e2q_pkg::mul30(cc_s1, sy_s1);
			ssc_s2 <= e2q_pkg::mul30(ss_s1, cy_s1);
			w_s3 <= ccc_s2 + sss_s2;
			x_s3 <= scc_s2 - css_s2;
			y_s3 <= csc_s2 + scs_s2;
			z_s3 <= ccs_s2 - ssc_s2;
		end
	end

	assign qw = finish(w_s3);
	assign qx = finish(x_s3);
	assign qy = finish(y_s3);
	assign qz = finish(z_s3);
endmodule
`default_nettype wire

/* design/euler_to_quaternion_core.sv */
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// zyx euler angles (degrees, 6 fraction bits) to unit quaternion, Q2.14
// ----------------------------------------------------------------------------
// channel  dir  payload
// s_axis   in   tdata[47:0] = roll, pitch, yaw
// m_axis   out  tdata[63:0] = w, x, y, z
//
// one transfer per cycle sustained while m_axis_tready keeps up; results pass the lane and merge registers
// three cordic lanes run side by side, the merge stage forms the products
// the whole pipeline advances when the output slot is free or empty
// arst_n clears only the valid bits; payload registers need no reset
// a stalled output holds its data, and s_axis_tready follows that stall
`default_nettype none
module euler_to_quaternion_core #(
	parameter int CORDIC_STAGES = 16,
	parameter int OUT_FRAC_BITS = 14
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// roll_deg [15:0], pitch_deg [31:16], yaw_deg [47:32]
	input  wire  [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
	output logic [63:0] m_axis_tdata
);
	localparam int NL = ((CORDIC_STAGES < e2q_pkg::ATAN_ENTRIES) ?
		CORDIC_STAGES : e2q_pkg::ATAN_ENTRIES);
	// lane: red_s1, z stage, N stages; merge: 3 stages
	localparam int LAT = NL + 5;

	logic [LAT-1:0] vld_q;
	logic en;
	e2q_pkg::sincos_t sc_r, sc_p, sc_y;
	logic signed [15:0] qw, qx, qy, qz;

	// advance when nothing waits at the output end
	assign en = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	e2q_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk), .en(en), .ang(s_axis_tdata[15:0]), .sc(sc_r));
	e2q_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
		.clk(clk), .en(en), .ang(s_axis_tdata[31:16]), .sc(sc_p));
	e2q_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
		.clk(clk), .en(en), .ang(s_axis_tdata[47:32]), .sc(sc_y));

	e2q_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
		.clk(clk), .en(en), .r(sc_r), .p(sc_p), .y(sc_y),
		.qw(qw), .qx(qx), .qy(qy), .qz(qz));

	assign m_axis_tvalid = vld_q[LAT-1];
	assign m_axis_tdata = {qz, qy, qx, qw};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && OUT_FRAC_BITS == 14 |-> qw >= -16'sd16400 && qw <= 16'sd16400)
		else $error("quaternion w out of unit range");
endmodule
`default_nettype wire
